// ===== src/ttocc_pkg.sv =====
// Types and constants for the truth-table orbit canonical check.
// Shared by truth_table_orbit_canonical_check and its testbench; depends on nothing else.
package ttocc_pkg;

    localparam int VARIABLES     = 5;
    localparam int VERTICES      = 32;
    localparam int PERMUTATIONS  = 120;
    localparam int ACTION_COUNT  = 240;
    localparam int VAR_W         = 3;
    localparam int ACTION_W      = 8;

    typedef logic [VARIABLES-1:0][VAR_W-1:0] perm_t;

    typedef struct packed {
        logic [VERTICES-1:0] code;
        logic                restart;
    } item_t;

    typedef struct packed {
        logic                canonical;
        logic [ACTION_W-1:0] witness_action;
        logic [31:0]         noncanonical_total;
        logic                any_bad;
        logic [31:0]         first_bad_row;
        logic [31:0]         first_bad_value;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WAIT
    } state_t;

endpackage

// ===== src/truth_table_orbit_canonical_check.sv =====
// Each accepted request is searched one action per cycle
// through a shared permute-and-compare unit, stopping at the first image or complemented
// image smaller than the code (240 actions max); the result is then registered once the output is free.
// One request at a time; the next request is taken only after the previous result is
// registered, later while an earlier result is stalled.
// Reset (rst_n, async, active low) clears the sequencer, output valid and all tallies.
module truth_table_orbit_canonical_check #(
    parameter int ROW_INDEX_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ttocc_pkg::item_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output ttocc_pkg::result_t result
);
    import ttocc_pkg::*;

    localparam logic [ACTION_W-1:0] LAST_ACTION = ACTION_W'(ACTION_COUNT - 1);
    localparam logic [ACTION_W-1:0] ALL_ACTIONS = ACTION_W'(ACTION_COUNT);

    // Lexicographic successor of a permutation.
    function automatic perm_t next_perm(input perm_t p);
        perm_t          s;
        perm_t          r;
        logic [VAR_W-1:0] i;
        logic [VAR_W-1:0] j;
        logic [VAR_W-1:0] t;
        logic [3:0]     k;
        i = '0;
        j = '0;
        for (int c = 0; c < VARIABLES - 1; c++) begin
            if (p[c] < p[c+1]) begin
                i = VAR_W'(c);
            end
        end
        for (int c = 0; c < VARIABLES; c++) begin
            if (p[c] > p[i]) begin
                j = VAR_W'(c);
            end
        end
        s    = p;
        t    = s[i];
        s[i] = s[j];
        s[j] = t;
        for (int a = 0; a < VARIABLES; a++) begin
            k = 4'(i) + 4'(VARIABLES) - 4'(a);
            if (VAR_W'(a) <= i) begin
                r[a] = s[a];
            end
            else begin
                r[a] = s[k[VAR_W-1:0]];
            end
        end
        return r;
    endfunction

    // Permute the table: bit v of the image is bit src(v) of the code.
    function automatic logic [VERTICES-1:0] image_of(input logic [VERTICES-1:0] c,
                                                     input perm_t p, input logic f);
        logic [VERTICES-1:0]  img;
        logic [7:0]           vb;
        logic [VARIABLES-1:0] src;
        img = '0;
        for (int v = 0; v < VERTICES; v++) begin
            vb = 8'(v);
            for (int b = 0; b < VARIABLES; b++) begin
                src[b] = vb[p[b]] ^ f;
            end
            img[v] = c[src];
        end
        return img;
    endfunction

    state_t state_reg, state_next;

    logic [VERTICES-1:0]       code_reg;
    logic                      restart_reg;
    perm_t                     perm_reg, perm_next;
    logic                      flip_reg, flip_next;
    logic [ACTION_W-1:0]       action_reg, action_next;
    logic                      smaller_reg, smaller_next;

    logic [ROW_INDEX_BITS-1:0] row_reg, row_next;
    logic [31:0]               tally_reg, tally_next;
    logic                      seen_reg, seen_next;
    logic [31:0]               first_row_reg, first_row_next;
    logic [31:0]               first_code_reg, first_code_next;

    logic                      out_valid_reg, out_valid_next;
    result_t                   out_reg, out_next;

    logic                      accept;
    logic                      hit;
    logic                      load;
    logic [VERTICES-1:0]       image;
    perm_t                     ident;
    logic [ROW_INDEX_BITS+31:0] row_wide;

    assign accept = item_valid && !item_stall;
    assign image  = image_of(code_reg, perm_reg, flip_reg);
    assign hit    = (image < code_reg) || ((~image) < code_reg);
    assign load   = (state_reg == ST_WAIT) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        for (int c = 0; c < VARIABLES; c++) begin
            ident[c] = VAR_W'(c);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (hit || action_reg == LAST_ACTION) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        item_stall      = (state_reg != ST_IDLE);
        perm_next       = perm_reg;
        flip_next       = flip_reg;
        action_next     = action_reg;
        smaller_next    = smaller_reg;
        row_next        = row_reg;
        tally_next      = tally_reg;
        seen_next       = seen_reg;
        first_row_next  = first_row_reg;
        first_code_next = first_code_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && result_stall;
        row_wide        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                perm_next    = ident;
                flip_next    = 1'b0;
                action_next  = '0;
                smaller_next = 1'b0;
            end
            ST_SEARCH:
            begin
                if (hit) begin
                    smaller_next = 1'b1;
                end
                else begin
                    // Advance to the next action: flip first, then the next permutation.
                    action_next = (action_reg == LAST_ACTION) ? ALL_ACTIONS
                                                              : action_reg + 1'b1;
                    flip_next   = !flip_reg;
                    if (flip_reg) begin
                        perm_next = next_perm(perm_reg);
                    end
                end
            end
            ST_WAIT:
            begin
                if (load) begin
                    if (restart_reg) begin
                        row_next        = '0;
                        tally_next      = '0;
                        seen_next       = 1'b0;
                        first_row_next  = '0;
                        first_code_next = '0;
                    end
                    row_wide = {32'b0, row_next};
                    if (smaller_reg) begin
                        if (tally_next != 32'hFFFF_FFFF) begin
                            tally_next = tally_next + 1'b1;
                        end
                        if (!seen_next) begin
                            seen_next       = 1'b1;
                            first_row_next  = row_wide[31:0];
                            first_code_next = code_reg;
                        end
                    end
                    row_next = row_next + 1'b1;

                    out_next.canonical          = !smaller_reg;
                    out_next.witness_action     = action_reg;
                    out_next.noncanonical_total = tally_next;
                    out_next.any_bad            = seen_next;
                    out_next.first_bad_row      = first_row_next;
                    out_next.first_bad_value    = first_code_next;
                    out_valid_next              = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            row_reg        <= '0;
            tally_reg      <= '0;
            seen_reg       <= 1'b0;
            first_row_reg  <= '0;
            first_code_reg <= '0;
        end
        else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            row_reg        <= row_next;
            tally_reg      <= tally_next;
            seen_reg       <= seen_next;
            first_row_reg  <= first_row_next;
            first_code_reg <= first_code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            code_reg    <= item.code;
            restart_reg <= item.restart;
        end
        perm_reg    <= perm_next;
        flip_reg    <= flip_next;
        action_reg  <= action_next;
        smaller_reg <= smaller_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== dv/truth_table_orbit_canonical_check_tb.sv =====
// Self-checking testbench for truth_table_orbit_canonical_check.
// Depends on ttocc_pkg; predicts each row's verdict and running tallies and
// compares every result; stimulus mixes orbit-minimal, near-minimal and raw codes.
module truth_table_orbit_canonical_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttocc_pkg::*;

    localparam int RANDOM_ROWS   = 1230;
    localparam int DRAIN_CYCLES  = 260;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        item_t req;
        bit    drain_first;
    } pending_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_HEAVY
    } rx_mode_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Input orders of the 120 permutations, lexicographic.
    perm_t var_orders [PERMUTATIONS];

    pending_row_t row_q [$];
    result_t      verdict_q [$];
    int           outstanding = 0;

    int burst_left = 1;
    int gap_left = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_mode_left = 0;

    // Predictor state.
    logic [31:0] next_row_idx;
    logic [31:0] noncanon_cnt;
    logic        bad_flag;
    logic [31:0] first_bad_idx;
    logic [31:0] first_bad_tt;

    int      mismatches = 0;
    int      results_seen = 0;
    result_t want;
    string   diffs;

    truth_table_orbit_canonical_check u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] table_image(logic [31:0] code, perm_t order, bit flip);
        logic [31:0] img;
        logic [4:0]  vtx;
        logic [4:0]  src;
        img = '0;
        for (int v = 0; v < VERTICES; v++)
        begin
            vtx = v[4:0];
            for (int c = 0; c < VARIABLES; c++)
                src[c] = vtx[order[c]] ^ flip;
            img[v] = code[src];
        end
        return img;
    endfunction

    function automatic logic [7:0] first_smaller_action(logic [31:0] code);
        logic [31:0] img;
        for (int a = 0; a < ACTION_COUNT; a++)
        begin
            img = table_image(code, var_orders[a / 2], a[0]);
            if (img < code || ~img < code)
                return 8'(a);
        end
        return 8'(ACTION_COUNT);
    endfunction

    // Smallest code over the whole orbit and its complements; always canonical.
    function automatic logic [31:0] orbit_floor(logic [31:0] code);
        logic [31:0] img;
        logic [31:0] low;
        low = code;
        for (int a = 0; a < ACTION_COUNT; a++)
        begin
            img = table_image(code, var_orders[a / 2], a[0]);
            if (img < low)
                low = img;
            if (~img < low)
                low = ~img;
        end
        return low;
    endfunction

    function automatic result_t classify_row(item_t req);
        result_t     r;
        logic [7:0]  act;
        logic [31:0] idx;
        if (req.restart)
        begin
            next_row_idx   = '0;
            noncanon_cnt   = '0;
            bad_flag       = 1'b0;
            first_bad_idx  = '0;
            first_bad_tt   = '0;
        end
        act = first_smaller_action(req.code);
        idx = next_row_idx;
        next_row_idx = next_row_idx + 1;
        if (act != 8'(ACTION_COUNT))
        begin
            if (noncanon_cnt != '1)
                noncanon_cnt = noncanon_cnt + 1;
            if (!bad_flag)
            begin
                bad_flag       = 1'b1;
                first_bad_idx  = idx;
                first_bad_tt   = req.code;
            end
        end
        r.canonical          = (act == 8'(ACTION_COUNT));
        r.witness_action     = act;
        r.noncanonical_total = noncanon_cnt;
        r.any_bad            = bad_flag;
        r.first_bad_row      = bad_flag ? first_bad_idx : '0;
        r.first_bad_value    = bad_flag ? first_bad_tt : '0;
        return r;
    endfunction

    function automatic void queue_row(logic [31:0] code, logic restart, bit drain_first);
        pending_row_t p;
        p.req.code    = code;
        p.req.restart = restart;
        p.drain_first = drain_first;
        row_q.push_back(p);
    endfunction

    function automatic logic [31:0] shaped_code();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom & $urandom;
            2: return $urandom | $urandom;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    // Sender: bursts of requests separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left   <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (row_q.size() > 0 &&
                     (!row_q[0].drain_first || (!item_valid && outstanding == 0)))
            begin
                item       <= row_q[0].req;
                item_valid <= 1'b1;
                row_q.delete(0);
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern switches between open, coin-flip and heavy phases.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_mode      <= RX_OPEN;
            rx_mode_left <= 0;
        end
        else if (rx_mode_left == 0)
        begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(50, 400);
            result_stall <= 1'b0;
        end
        else
        begin
            rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                RX_COIN:  result_stall <= $urandom_range(0, 1);
                RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                default:  result_stall <= 1'b0;
            endcase
        end
    end

    // Monitor: check results in order, then predict any request taken at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_row_idx   = '0;
            noncanon_cnt   = '0;
            bad_flag       = 1'b0;
            first_bad_idx  = '0;
            first_bad_tt   = '0;
            outstanding   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result %0d: %p", results_seen, result);
                end
                else
                begin
                    want  = verdict_q.pop_front();
                    diffs = "";
                    if (result.canonical !== want.canonical)
                        diffs = {diffs, " canonical"};
                    if (result.witness_action !== want.witness_action)
                        diffs = {diffs, " witness_action"};
                    if (result.noncanonical_total !== want.noncanonical_total)
                        diffs = {diffs, " noncanonical_total"};
                    if (result.any_bad !== want.any_bad)
                        diffs = {diffs, " any_bad"};
                    if (result.first_bad_row !== want.first_bad_row)
                        diffs = {diffs, " first_bad_row"};
                    if (result.first_bad_value !== want.first_bad_value)
                        diffs = {diffs, " first_bad_value"};
                    if (diffs != "")
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result %0d differs in%s\n  expected %p\n  actual   %p",
                                     results_seen, diffs, want, result);
                    end
                end
                results_seen++;
            end
            if (item_valid && !item_stall)
                verdict_q.push_back(classify_row(item));
            outstanding <= verdict_q.size();
        end
    end

    initial
    begin
        int          n;
        int          d;
        logic [7:0]  used;
        bit          distinct;
        perm_t       order;
        logic [31:0] code;
        int          pick;

        n = 0;
        for (int k = 0; k < VARIABLES ** VARIABLES; k++)
        begin
            d        = k;
            used     = '0;
            distinct = 1'b1;
            for (int c = VARIABLES - 1; c >= 0; c--)
            begin
                order[c] = VAR_W'(d % VARIABLES);
                d = d / VARIABLES;
                if (used[order[c]])
                    distinct = 1'b0;
                used[order[c]] = 1'b1;
            end
            if (distinct)
            begin
                var_orders[n] = order;
                n++;
            end
        end

        // Directed rows: canonical rows before any bad one, complements, parity,
        // single-vertex tables, and restarts on bad and on canonical rows.
        queue_row(32'h0000_0000, 1'b1, 1'b0);
        queue_row(32'h0000_0001, 1'b0, 1'b0);
        queue_row(32'h0000_0002, 1'b0, 1'b0);
        queue_row(32'h0000_0004, 1'b0, 1'b0);
        queue_row(32'h0000_FFFF, 1'b0, 1'b0);
        queue_row(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_row(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_row(32'h8000_0000, 1'b0, 1'b0);
        queue_row(32'hAAAA_AAAA, 1'b0, 1'b0);
        queue_row(32'h5555_5555, 1'b0, 1'b0);
        queue_row(32'h0000_0116, 1'b0, 1'b0);
        queue_row(32'h0001_0117, 1'b0, 1'b0);
        queue_row(32'h1234_5678, 1'b0, 1'b0);
        queue_row(32'hFFFF_0000, 1'b0, 1'b0);
        queue_row(32'h6996_9669, 1'b0, 1'b0);
        queue_row(32'h9669_6996, 1'b0, 1'b0);
        queue_row(32'h0000_0004, 1'b1, 1'b0);
        queue_row(32'h0000_0001, 1'b1, 1'b0);
        queue_row(32'h0000_0003, 1'b0, 1'b0);
        queue_row(32'h0000_0017, 1'b0, 1'b0);
        queue_row(32'hFFFF_FFFE, 1'b0, 1'b0);

        for (int i = 0; i < RANDOM_ROWS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                code = orbit_floor(shaped_code());
            else if (pick < 55)
                code = orbit_floor(shaped_code()) ^ (32'h1 << $urandom_range(0, 31));
            else
                code = shaped_code();
            queue_row(code, ($urandom_range(0, 49) == 0),
                      (i == 0 || i == RANDOM_ROWS / 2));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (row_q.size() != 0 || item_valid)
            @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("** truth_table_orbit_canonical_check: PASSED **");
        else
            $display("** truth_table_orbit_canonical_check: FAILED **");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("timeout with %0d results pending", verdict_q.size());
        $display("** truth_table_orbit_canonical_check: FAILED **");
        $finish;
    end

endmodule
